// File: design/pldc_pkg.sv
package pldc_pkg;

   localparam int HIST_DEPTH_DEF = 2048;
   localparam int OUT_MAX_DEF = 4096;

   localparam int BYTE_W = 8;
   localparam int LIMIT_W = 13;
   localparam int TOTAL_W = 13;
   localparam int STATUS_W = 2;
   localparam int DIST_W = 11;
   localparam int LEN_BITS = 3;

   // Token byte classes.
   localparam logic [BYTE_W-1:0] LIT_RUN_MIN = 8'h01;
   localparam logic [BYTE_W-1:0] LIT_RUN_MAX = 8'h08;
   localparam logic [BYTE_W-1:0] PAIR_BASE = 8'h80;
   localparam logic [BYTE_W-1:0] SPACE_BASE = 8'hC0;
   localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [BYTE_W-1:0] SPACE_XOR = 8'h80;
   localparam logic [15:0] DIST_MASK = 16'h3FFF;
   localparam logic [3:0] MATCH_MIN = 4'd3;
   localparam logic [3:0] HOLD_MAX = 4'd8;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_TRUNC = 2'd1,
      ST_LIMIT = 2'd2,
      ST_DIST  = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                has_byte;
      logic                run_last;
      logic                record_end;
      logic [STATUS_W-1:0] status;
      logic [TOTAL_W-1:0]  total_len;
   } rsp_item_type;

endpackage

// File: design/pldc_req_if.sv
interface pldc_req_if;
   import pldc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink (input valid, input in_byte, input is_last, output ready);

endinterface

// File: design/pldc_rsp_if.sv
interface pldc_rsp_if;
   import pldc_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                has_byte;
   logic                run_last;
   logic                record_end;
   logic [STATUS_W-1:0] status;
   logic [TOTAL_W-1:0]  total_len;

   modport source (output valid, output out_byte, output has_byte, output run_last,
                   output record_end, output status, output total_len, input ready);
   modport sink (input valid, input out_byte, input has_byte, input run_last,
                 input record_end, input status, input total_len, output ready);

endinterface

// File: design/pldc_hist_ram.sv
module pldc_hist_ram #(
   parameter int HISTORY_DEPTH = pldc_pkg::HIST_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
   input  logic [pldc_pkg::BYTE_W-1:0]      wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
   output logic [pldc_pkg::BYTE_W-1:0]      rd_data
);
   import pldc_pkg::*;

   logic [BYTE_W-1:0] hist_mem [HISTORY_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   // A read of the entry being written returns the new byte, which a copy at
   // distance one depends on.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : hist_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/pldc_ctrl.sv
module pldc_ctrl #(
   parameter int HISTORY_DEPTH = pldc_pkg::HIST_DEPTH_DEF,
   parameter int OUT_MAX = pldc_pkg::OUT_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pldc_pkg::BYTE_W-1:0]   req_in_byte,
   input  logic                          req_is_last,
   input  logic [$clog2(OUT_MAX+1)-1:0]  limit,
   input  logic                          out_free,
   output logic                          emit_valid,
   output pldc_pkg::rsp_item_type        emit_item
);
   import pldc_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(OUT_MAX + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EMIT = 4'b0010,
      S_COPY = 4'b0100,
      S_END  = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      MODE_TOKEN   = 3'b001,
      MODE_LITERAL = 3'b010,
      MODE_PAIR    = 3'b100
   } mode_type;

   state_type               state_ff, state_in;
   mode_type                mode_ff, mode_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [3:0]              left_ff, left_in;
   logic [3:0]              fill_ff, fill_in;
   logic [BYTE_W-1:0]       pair_high_ff, pair_high_in;
   logic                    stopped_ff, stopped_in;
   status_type              stop_status_ff, stop_status_in;
   logic [3:0]              remain_ff, remain_in;
   logic [2:0]              idx_ff, idx_in;
   logic                    end_ff, end_in;
   status_type              end_status_ff, end_status_in;
   logic [7:0][BYTE_W-1:0]  hold_ff, hold_in;

   logic                    clear;
   logic [3:0]              n_emit;
   logic                    copy_go;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [BYTE_W-1:0]       rd_data;
   logic                    hist_we;

   logic [3:0]              fill_nx;
   logic [3:0]              left_nx;
   logic [15:0]             pair_word;
   logic [DIST_W-1:0]       match_dist;
   logic [3:0]              copy_len;
   logic [AW:0]             src_diff;
   logic [AW-1:0]           src_addr;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == AW'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic over_limit(input logic [CW-1:0] cnt, input logic [CW-1:0] lim,
                                       input logic [3:0] need);
      return ({1'b0, cnt} + (CW+1)'(need)) > {1'b0, lim};
   endfunction

   assign fill_nx = fill_ff + 1'b1;
   assign left_nx = (left_ff != '0) ? left_ff - 1'b1 : '0;
   assign pair_word = {pair_high_ff, req_in_byte};
   assign match_dist = DIST_W'((pair_word & DIST_MASK) >> LEN_BITS);
   assign copy_len = {1'b0, pair_word[LEN_BITS-1:0]} + MATCH_MIN;
   assign src_diff = {1'b0, wr_ptr_ff} - (AW+1)'(match_dist);
   assign src_addr = src_diff[AW] ? AW'(src_diff + (AW+1)'(HISTORY_DEPTH)) : src_diff[AW-1:0];

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      count_in       = count_ff;
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      left_in        = left_ff;
      fill_in        = fill_ff;
      pair_high_in   = pair_high_ff;
      stopped_in     = stopped_ff;
      stop_status_in = stop_status_ff;
      remain_in      = remain_ff;
      idx_in         = idx_ff;
      end_in         = end_ff;
      end_status_in  = end_status_ff;
      hold_in        = hold_ff;
      clear          = 1'b0;
      n_emit         = '0;
      copy_go        = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = rd_ptr_ff;
      hist_we        = 1'b0;
      emit_valid     = 1'b0;
      emit_item      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!stopped_ff) begin
                  case (mode_ff)
                     MODE_TOKEN: begin
                        if (req_in_byte inside {[LIT_RUN_MIN : LIT_RUN_MAX]}) begin
                           mode_in = MODE_LITERAL;
                           left_in = req_in_byte[3:0];
                           fill_in = '0;
                        end else if (req_in_byte < PAIR_BASE) begin
                           if (over_limit(count_ff, limit, 4'd1)) begin
                              stopped_in = 1'b1;
                              stop_status_in = ST_LIMIT;
                           end else begin
                              hold_in[0] = req_in_byte;
                              n_emit = 4'd1;
                           end
                        end else if (req_in_byte >= SPACE_BASE) begin
                           if (over_limit(count_ff, limit, 4'd2)) begin
                              stopped_in = 1'b1;
                              stop_status_in = ST_LIMIT;
                           end else begin
                              hold_in[0] = SPACE_CHAR;
                              hold_in[1] = req_in_byte ^ SPACE_XOR;
                              n_emit = 4'd2;
                           end
                        end else begin
                           pair_high_in = req_in_byte;
                           mode_in = MODE_PAIR;
                        end
                     end
                     MODE_LITERAL: begin
                        hold_in[fill_ff[2:0]] = req_in_byte;
                        if ((left_nx == '0) || (fill_nx >= HOLD_MAX)) begin
                           mode_in = MODE_TOKEN;
                           left_in = '0;
                           fill_in = '0;
                           if (over_limit(count_ff, limit, fill_nx)) begin
                              stopped_in = 1'b1;
                              stop_status_in = ST_LIMIT;
                           end else begin
                              n_emit = fill_nx;
                           end
                        end else begin
                           fill_in = fill_nx;
                           left_in = left_nx;
                        end
                     end
                     MODE_PAIR: begin
                        mode_in = MODE_TOKEN;
                        if (over_limit(count_ff, limit, copy_len)) begin
                           stopped_in = 1'b1;
                           stop_status_in = ST_LIMIT;
                        end else if ((match_dist == '0) ||
                                     (32'(match_dist) > 32'(count_ff))) begin
                           stopped_in = 1'b1;
                           stop_status_in = ST_DIST;
                        end else begin
                           n_emit = copy_len;
                           copy_go = 1'b1;
                        end
                     end
                     default: mode_in = MODE_TOKEN;
                  endcase
                  // A record that ends inside a literal run or a pair is truncated.
                  if (req_is_last && (mode_in != MODE_TOKEN) && !stopped_in) begin
                     stopped_in = 1'b1;
                     stop_status_in = ST_TRUNC;
                     mode_in = MODE_TOKEN;
                  end
               end
               if (n_emit != '0) begin
                  state_in = copy_go ? S_COPY : S_EMIT;
                  remain_in = n_emit;
                  idx_in = '0;
                  end_in = req_is_last;
                  if (copy_go) begin
                     rd_en = 1'b1;
                     rd_addr = src_addr;
                     rd_ptr_in = ptr_inc(src_addr);
                  end
               end else if (req_is_last) begin
                  state_in = S_END;
                  end_status_in = stopped_in ? stop_status_in : ST_OK;
               end
            end
         end
         S_EMIT, S_COPY: begin
            if (out_free) begin
               emit_valid = 1'b1;
               hist_we = 1'b1;
               emit_item.out_byte = (state_ff == S_COPY) ? rd_data : hold_ff[idx_ff];
               emit_item.has_byte = 1'b1;
               emit_item.run_last = (remain_ff == 4'd1);
               emit_item.record_end = (remain_ff == 4'd1) && end_ff;
               emit_item.status = ST_OK;
               emit_item.total_len = TOTAL_W'({1'b0, count_ff} + 1'b1);
               count_in = count_ff + 1'b1;
               wr_ptr_in = ptr_inc(wr_ptr_ff);
               idx_in = idx_ff + 1'b1;
               remain_in = remain_ff - 1'b1;
               if (remain_ff == 4'd1) begin
                  state_in = S_IDLE;
                  clear = end_ff;
               end else if (state_ff == S_COPY) begin
                  rd_en = 1'b1;
                  rd_addr = rd_ptr_ff;
                  rd_ptr_in = ptr_inc(rd_ptr_ff);
               end
            end
         end
         S_END: begin
            if (out_free) begin
               emit_valid = 1'b1;
               emit_item.run_last = 1'b1;
               emit_item.record_end = 1'b1;
               emit_item.status = end_status_ff;
               emit_item.total_len = TOTAL_W'(count_ff);
               state_in = S_IDLE;
               clear = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (clear) begin
         count_in = '0;
         wr_ptr_in = '0;
         mode_in = MODE_TOKEN;
         left_in = '0;
         fill_in = '0;
         pair_high_in = '0;
         stopped_in = 1'b0;
         stop_status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         mode_ff        <= MODE_TOKEN;
         count_ff       <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         left_ff        <= '0;
         fill_ff        <= '0;
         pair_high_ff   <= '0;
         stopped_ff     <= 1'b0;
         stop_status_ff <= ST_OK;
         remain_ff      <= '0;
         idx_ff         <= '0;
         end_ff         <= 1'b0;
         end_status_ff  <= ST_OK;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         count_ff       <= count_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         left_ff        <= left_in;
         fill_ff        <= fill_in;
         pair_high_ff   <= pair_high_in;
         stopped_ff     <= stopped_in;
         stop_status_ff <= stop_status_in;
         remain_ff      <= remain_in;
         idx_ff         <= idx_in;
         end_ff         <= end_in;
         end_status_ff  <= end_status_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   pldc_hist_ram #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (emit_item.out_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// File: design/palmdoc_lz77_decompressor.sv
// Channel   Direction  Handshake      Payload
// req_if    in         valid/ready    in_byte, is_last
// rsp_if    out        valid/ready    out_byte, has_byte, run_last, record_end,
//                                     status, total_len
// csr       in         csr_we         csr_wdata (output limit)
//
// A request is taken in S_IDLE; one that yields bytes holds the sequencer, one byte
// per cycle unless rsp_if stalls; a back-reference yields up to 10 bytes.
// A record end without bytes adds a status-only result.
// The byte rate is set by the single history memory port pair, read registered ahead.
// Reset is synchronous; history contents are not cleared and need no clearing pass.
// A stalled rsp_if holds the sequencer in place; req_if.ready is high only in S_IDLE.
module palmdoc_lz77_decompressor #(
   parameter int HISTORY_DEPTH = pldc_pkg::HIST_DEPTH_DEF,
   parameter int OUT_MAX = pldc_pkg::OUT_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [pldc_pkg::LIMIT_W-1:0] csr_wdata,
   pldc_req_if.sink                     req_if,
   pldc_rsp_if.source                   rsp_if
);
   import pldc_pkg::*;

   localparam int CW = $clog2(OUT_MAX + 1);

   logic [CW-1:0] limit_ff, limit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_data_ff, rsp_data_in;
   logic          out_free;
   logic          emit_valid;
   rsp_item_type  emit_item;

   // The limit in use is the lesser of the written value and OUT_MAX.
   always_comb begin
      limit_in = limit_ff;
      if (csr_we) begin
         limit_in = (32'(csr_wdata) < OUT_MAX) ? CW'(csr_wdata) : CW'(OUT_MAX);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = emit_item;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CW'(OUT_MAX);
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_byte   = rsp_data_ff.out_byte;
   assign rsp_if.has_byte   = rsp_data_ff.has_byte;
   assign rsp_if.run_last   = rsp_data_ff.run_last;
   assign rsp_if.record_end = rsp_data_ff.record_end;
   assign rsp_if.status     = rsp_data_ff.status;
   assign rsp_if.total_len  = rsp_data_ff.total_len;

   pldc_ctrl #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .OUT_MAX(OUT_MAX)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_in_byte (req_if.in_byte),
      .req_is_last (req_if.is_last),
      .limit       (limit_ff),
      .out_free    (out_free),
      .emit_valid  (emit_valid),
      .emit_item   (emit_item)
   );

endmodule
